// ===== rtl/core/transpose_matrix_multiply_macros.svh =====
// ----------------------------------------------------------------------------
// transpose_matrix_multiply_macros
// assertion helpers shared by the transpose-multiply rtl
// ----------------------------------------------------------------------------
`ifndef TRANSPOSE_MATRIX_MULTIPLY_MACROS_SVH
`define TRANSPOSE_MATRIX_MULTIPLY_MACROS_SVH

// same-cycle implication, checked out of reset
`define TMM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tmm_pkg.sv =====
// ----------------------------------------------------------------------------
// tmm_pkg
// shared widths, request codes and the term control bundle
// ----------------------------------------------------------------------------
package tmm_pkg;

  localparam int DEFAULT_MAX_DIM = 8;

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int RES_W     = 48;
  localparam int POS_W     = 3;
  localparam int DIM_REG_W = 4;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 2'd2;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

  // one multiply-accumulate term, issued alongside the store reads
  typedef struct packed {
    logic             valid;
    logic             is_first;
    logic             is_last;
    logic             res_last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tmm_term_t;

endpackage

// ===== rtl/core/tmm_ram.sv =====
// ----------------------------------------------------------------------------
// tmm_ram
// generic simple dual-port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module tmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tmm_seq.sv =====
// ----------------------------------------------------------------------------
// tmm_seq
// request decode, store writes and the i/k/j read sequencer
// ----------------------------------------------------------------------------
module tmm_seq
  import tmm_pkg::*;
#(
  parameter int MAX_DIM = DEFAULT_MAX_DIM,
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int CNT_W  = $clog2(MAX_DIM + 1),
  localparam int ADDR_W = 2 * IDX_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [POS_W-1:0]  elem_row,
  input  logic [POS_W-1:0]  elem_col,
  input  logic [ELEM_W-1:0] elem_value,
  input  logic [CNT_W-1:0]  dim_m,
  input  logic [CNT_W-1:0]  dim_n,
  input  logic [CNT_W-1:0]  dim_l,
  input  logic              mac_busy,
  output logic              a_wr_en,
  output logic              b_wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ELEM_W-1:0] wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] a_rd_addr,
  output logic [ADDR_W-1:0] b_rd_addr,
  output tmm_term_t         term
);

`include "transpose_matrix_multiply_macros.svh"

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [CNT_W-1:0] m_r, m_nxt, n_r, n_nxt, l_r, l_nxt;
  logic             done_all_r, done_all_nxt;

  logic accept;
  logic in_range;
  logic j_end, k_end, i_end;

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req_valid && req_ready;

  // writes outside the stored square are never read back
  assign in_range = (DIM_REG_W'(elem_row) < DIM_REG_W'(MAX_DIM)) &&
                    (DIM_REG_W'(elem_col) < DIM_REG_W'(MAX_DIM));
  assign a_wr_en  = accept && (req_type == REQ_WRITE_A) && in_range;
  assign b_wr_en  = accept && (req_type == REQ_WRITE_B) && in_range;
  assign wr_addr  = {elem_row[IDX_W-1:0], elem_col[IDX_W-1:0]};
  assign wr_data  = elem_value;

  assign j_end = (CNT_W'(j_r) + CNT_W'(1)) == m_r;
  assign k_end = (CNT_W'(k_r) + CNT_W'(1)) == l_r;
  assign i_end = (CNT_W'(i_r) + CNT_W'(1)) == n_r;

  // A[j][i] and B[j][k]
  assign rd_en     = (state_r == S_ISSUE);
  assign a_rd_addr = {j_r, i_r};
  assign b_rd_addr = {j_r, k_r};

  always_comb begin
    term          = '0;
    term.valid    = (state_r == S_ISSUE);
    term.is_first = (j_r == '0);
    term.is_last  = j_end;
    term.res_last = i_end && k_end;
    term.row      = POS_W'(i_r);
    term.col      = POS_W'(k_r);
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    m_nxt        = m_r;
    n_nxt        = n_r;
    l_nxt        = l_r;
    done_all_nxt = done_all_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (req_type == REQ_COMPUTE) &&
            (dim_m != '0) && (dim_n != '0) && (dim_l != '0)) begin
          m_nxt        = dim_m;
          n_nxt        = dim_n;
          l_nxt        = dim_l;
          i_nxt        = '0;
          k_nxt        = '0;
          j_nxt        = '0;
          done_all_nxt = 1'b0;
          state_nxt    = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (j_end) begin
          j_nxt     = '0;
          state_nxt = S_WAIT;
          if (k_end) begin
            k_nxt = '0;
            if (i_end) begin
              done_all_nxt = 1'b1;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (!mac_busy) begin
          state_nxt = done_all_r ? S_IDLE : S_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      done_all_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      done_all_r <= done_all_nxt;
    end
    i_r <= i_nxt;
    k_r <= k_nxt;
    j_r <= j_nxt;
    m_r <= m_nxt;
    n_r <= n_nxt;
    l_r <= l_nxt;
  end

  `TMM_ASSERT_IMPL(a_start_on_empty_mac, (state_r == S_ISSUE) && (j_r == '0), !mac_busy, "dot product started while mac still busy")
  `TMM_ASSERT_IMPL(a_index_in_range, state_r == S_ISSUE, (CNT_W'(j_r) < m_r) && (CNT_W'(i_r) < n_r) && (CNT_W'(k_r) < l_r), "sequencer index out of range")

endmodule

// ===== rtl/core/tmm_mac.sv =====
// ----------------------------------------------------------------------------
// tmm_mac
// multiply, accumulate and result register with valid/ready output
// ----------------------------------------------------------------------------
module tmm_mac
  import tmm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  tmm_term_t                term,
  input  logic [ELEM_W-1:0]        rd_a,
  input  logic [ELEM_W-1:0]        rd_b,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POS_W-1:0]         out_res_row,
  output logic [POS_W-1:0]         out_res_col,
  output logic signed [RES_W-1:0]  out_res_value,
  output logic                     out_res_last
);

`include "transpose_matrix_multiply_macros.svh"

  tmm_term_t                c1_r, c2_r;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [RES_W-1:0]  acc_r, acc_nxt;
  logic                     done_r, done_nxt;
  logic [POS_W-1:0]         done_row_r, done_col_r;
  logic                     done_last_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     load_out;

  assign prod_nxt = $signed(rd_a) * $signed(rd_b);
  assign acc_nxt  = (c2_r.is_first ? '0 : acc_r) +
                    {{(RES_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign load_out = done_r && (!out_valid_r || out_ready);
  assign done_nxt = (c2_r.valid && c2_r.is_last) || (done_r && !load_out);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign busy      = c1_r.valid || c2_r.valid || done_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r        <= '0;
      c2_r        <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      c1_r        <= term;
      c2_r        <= c1_r;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r <= prod_nxt;
    if (c2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (c2_r.valid && c2_r.is_last) begin
      done_row_r  <= c2_r.row;
      done_col_r  <= c2_r.col;
      done_last_r <= c2_r.res_last;
    end
    if (load_out) begin
      out_res_row   <= done_row_r;
      out_res_col   <= done_col_r;
      out_res_value <= acc_r;
      out_res_last  <= done_last_r;
    end
  end

  `TMM_ASSERT_IMPL(a_no_overrun, done_r, !(c1_r.valid || c2_r.valid), "term arrived while a result was pending")
  `TMM_ASSERT_NEXT(a_done_after_last, c2_r.valid && c2_r.is_last, done_r, "final term did not raise done")

endmodule

// ===== rtl/core/transpose_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// transpose_matrix_multiply
// R = transpose(A) * B over two element stores, Q4.12 in, exact Q24.24 out
// ----------------------------------------------------------------------------
// loads: a load request is written in the cycle it is taken, one per idle cycle
// compute: each result runs its m terms through one shared mac (store read,
//   product register, accumulator); the next result waits for the mac to drain
// no request is taken while a compute runs; a result may wait in the output
//   register while loads go on
// reset (rst_n, synchronous, active low) sets all three dimensions to 8 and
//   empties the pipeline; the stores stay undefined until written
module transpose_matrix_multiply
  import tmm_pkg::*;
#(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_REG_W-1:0]     cfg_wdata,
  // request channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic [POS_W-1:0]         in_elem_row,
  input  logic [POS_W-1:0]         in_elem_col,
  input  logic signed [ELEM_W-1:0] in_elem_value,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [POS_W-1:0]         out_res_row,
  output logic [POS_W-1:0]         out_res_col,
  output logic signed [RES_W-1:0]  out_res_value,
  output logic                     out_res_last
);

`include "transpose_matrix_multiply_macros.svh"

  // store index bits per dimension and the width of a dimension count
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W     = $clog2(MAX_DIM + 1);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  logic [DIM_REG_W-1:0] inner_len_r, out_rows_r, out_cols_r;
  logic [CNT_W-1:0]     dim_m, dim_n, dim_l;

  logic              a_wr_en, b_wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
  logic [ELEM_W-1:0] wr_data, rd_a, rd_b;
  logic              mac_busy;
  tmm_term_t         term;

  // dimension registers, indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_len_r <= DIM_RESET;
      out_rows_r  <= DIM_RESET;
      out_cols_r  <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INNER_LEN: inner_len_r <= cfg_wdata;
        CFG_OUT_ROWS:  out_rows_r  <= cfg_wdata;
        CFG_OUT_COLS:  out_cols_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // oversized dimensions saturate to the store side
  always_comb begin
    dim_m = (inner_len_r > DIM_REG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(inner_len_r);
    dim_n = (out_rows_r > DIM_REG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(out_rows_r);
    dim_l = (out_cols_r > DIM_REG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(out_cols_r);
  end

  // request decode and term sequencing
  tmm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req_type   (in_req_type),
    .elem_row   (in_elem_row),
    .elem_col   (in_elem_col),
    .elem_value (in_elem_value),
    .dim_m      (dim_m),
    .dim_n      (dim_n),
    .dim_l      (dim_l),
    .mac_busy   (mac_busy),
    .a_wr_en    (a_wr_en),
    .b_wr_en    (b_wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .a_rd_addr  (a_rd_addr),
    .b_rd_addr  (b_rd_addr),
    .term       (term)
  );

  // element store for A, addressed {row, col}
  tmm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (RAM_DEPTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (rd_a)
  );

  // element store for B, addressed {row, col}
  tmm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (RAM_DEPTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (rd_b)
  );

  // product, accumulator and output register
  tmm_mac u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .term          (term),
    .rd_a          (rd_a),
    .rd_b          (rd_b),
    .busy          (mac_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_res_row   (out_res_row),
    .out_res_col   (out_res_col),
    .out_res_value (out_res_value),
    .out_res_last  (out_res_last)
  );

  // no store write may land while terms are being read
  `TMM_ASSERT_IMPL(a_no_write_during_read, rd_en, !(a_wr_en || b_wr_en), "store write during compute read")

endmodule
